// ===== rtl/rwl_pkg.sv =====
// Types and constants of the reader/writer lock table.
// No dependencies; used by rwl_front, rwl_back and the top level.

package rwl_pkg;

    // Input and output field widths
    localparam int OP_W     = 2;
    localparam int CLIENT_W = 4;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 3;

    // Stream data widths, padded to whole bytes
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // Depth of the command queue between front and back
    localparam int QDEPTH   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_ABANDON = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd2;

    // Client marks
    localparam logic [MARK_W-1:0] MARK_FREE   = 3'd0;
    localparam logic [MARK_W-1:0] MARK_WRITER = 3'd1;
    localparam logic [MARK_W-1:0] MARK_READ0  = 3'd2;
    localparam logic [MARK_W-1:0] MARK_READ1  = 3'd3;
    localparam logic [MARK_W-1:0] MARK_WAIT   = 3'd5;

    typedef logic [MARK_W-1:0] t_mark;

    // Classified command kinds
    typedef enum logic [2:0] {
        K_ACQ_RD  = 3'd0,
        K_ACQ_WR  = 3'd1,
        K_ABANDON = 3'd2,
        K_RELEASE = 3'd3,
        K_NOP     = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CLIENT_W-1:0] client;
    } t_cmd;

endpackage

// ===== rtl/rwl_front.sv =====
// Front part of the lock table: accepts request beats, classifies them
// and holds them in a short command queue. Depends on rwl_pkg.

module rwl_front #(
    parameter int NUM_CLIENTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rwl_pkg::OP_W-1:0]      i_op,
    input  logic [rwl_pkg::CLIENT_W-1:0]  i_client,
    input  logic                          i_want_read,
    output logic                          o_q_valid,
    output rwl_pkg::t_cmd                 o_q_cmd,
    input  logic                          i_q_pop
);

    localparam int PTR_W = $clog2(rwl_pkg::QDEPTH);
    localparam int CNT_W = $clog2(rwl_pkg::QDEPTH + 1);

    rwl_pkg::t_cmd  cls_cmd;
    rwl_pkg::t_cmd  r_slot [rwl_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push;
    logic             pop;

    // Classify: out-of-range clients and unused ops become no-ops
    always_comb begin
        cls_cmd.client = i_client;
        case (i_op)
            rwl_pkg::OP_ACQUIRE: begin
                cls_cmd.kind = i_want_read ? rwl_pkg::K_ACQ_RD : rwl_pkg::K_ACQ_WR;
            end
            rwl_pkg::OP_ABANDON: cls_cmd.kind = rwl_pkg::K_ABANDON;
            rwl_pkg::OP_RELEASE: cls_cmd.kind = rwl_pkg::K_RELEASE;
            default:             cls_cmd.kind = rwl_pkg::K_NOP;
        endcase
        if (32'(i_client) >= NUM_CLIENTS) begin
            cls_cmd.kind = rwl_pkg::K_NOP;
        end
    end

    assign o_ready   = (r_count != CNT_W'(rwl_pkg::QDEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule

// ===== rtl/rwl_back.sv =====
// Back part of the lock table: evaluates one queued command against the
// client marks, writes back the mark and toggle, and holds the result beat.
// Depends on rwl_pkg.

module rwl_back #(
    parameter int NUM_CLIENTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic                          i_cfg_wdata,
    input  logic                          i_q_valid,
    input  rwl_pkg::t_cmd                 i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rwl_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_area,
    output logic                          o_others_waiting
);

    localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state         r_state, n_state;
    rwl_pkg::t_cmd  r_cmd;
    rwl_pkg::t_mark r_marks [NUM_CLIENTS];
    logic           r_split;
    logic           r_toggle, n_toggle;

    // Summaries over the other clients and the own writer mark, registered in EVAL
    logic r_any_wr,   n_any_wr;
    logic r_any_busy, n_any_busy;
    logic r_any_wait, n_any_wait;
    logic r_self_wr,  n_self_wr;

    logic                          r_out_valid;
    logic [rwl_pkg::STATUS_W-1:0]  r_out_status, n_status;
    logic                          r_out_area;
    logic                          r_out_others;

    logic           out_free;
    logic           commit;
    logic           mark_we;
    rwl_pkg::t_mark mark_val;
    logic [IDX_W-1:0] idx;

    assign idx      = IDX_W'(r_cmd.client);
    assign out_free = !r_out_valid || i_ready;
    assign commit   = (r_state == S_COMMIT) && out_free;
    assign o_q_pop  = ((r_state == S_IDLE) || commit) && i_q_valid;

    // Parallel compare over all marks
    always_comb begin
        n_any_wr   = 1'b0;
        n_any_busy = 1'b0;
        n_any_wait = 1'b0;
        n_self_wr  = 1'b0;
        for (int i = 0; i < NUM_CLIENTS; i++) begin
            if (32'(r_cmd.client) == i) begin
                n_self_wr = n_self_wr || (r_marks[i] == rwl_pkg::MARK_WRITER);
            end else begin
                n_any_wr   = n_any_wr || (r_marks[i] == rwl_pkg::MARK_WRITER);
                n_any_busy = n_any_busy || ((r_marks[i] != rwl_pkg::MARK_FREE) &&
                                            (r_marks[i] != rwl_pkg::MARK_WAIT));
                n_any_wait = n_any_wait || (r_marks[i] == rwl_pkg::MARK_WAIT);
            end
        end
    end

    // Decide the new mark, toggle and status
    always_comb begin
        mark_we  = 1'b0;
        mark_val = rwl_pkg::MARK_FREE;
        n_toggle = r_toggle;
        n_status = rwl_pkg::ST_DONE;
        case (r_cmd.kind)
            rwl_pkg::K_ACQ_RD: begin
                mark_we = 1'b1;
                if (r_split) begin
                    mark_val = rwl_pkg::MARK_READ0 | {2'b00, r_toggle};
                    n_status = rwl_pkg::ST_GRANTED;
                end else if (!r_any_wr) begin
                    mark_val = rwl_pkg::MARK_READ0;
                    n_status = rwl_pkg::ST_GRANTED;
                end else begin
                    mark_val = rwl_pkg::MARK_WAIT;
                    n_status = rwl_pkg::ST_BUSY;
                end
            end
            rwl_pkg::K_ACQ_WR: begin
                mark_we = 1'b1;
                if (!r_any_busy) begin
                    mark_val = rwl_pkg::MARK_WRITER;
                    n_status = rwl_pkg::ST_GRANTED;
                end else begin
                    mark_val = rwl_pkg::MARK_WAIT;
                    n_status = rwl_pkg::ST_BUSY;
                end
            end
            rwl_pkg::K_ABANDON: begin
                mark_we = 1'b1;
            end
            rwl_pkg::K_RELEASE: begin
                mark_we = 1'b1;
                if (r_split && r_self_wr) begin
                    n_toggle = !r_toggle;
                end
            end
            default: begin
                mark_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_q_valid) n_state = S_EVAL;
            S_EVAL:   n_state = S_COMMIT;
            S_COMMIT: if (commit) n_state = i_q_valid ? S_EVAL : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_split     <= 1'b0;
            r_toggle    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                r_marks[i] <= rwl_pkg::MARK_FREE;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_split <= i_cfg_wdata;
            end
            if (commit) begin
                r_toggle    <= n_toggle;
                r_out_valid <= 1'b1;
                if (mark_we) begin
                    r_marks[idx] <= mark_val;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == S_EVAL) begin
            r_any_wr   <= n_any_wr;
            r_any_busy <= n_any_busy;
            r_any_wait <= n_any_wait;
            r_self_wr  <= n_self_wr;
        end
        if (commit) begin
            r_out_status <= n_status;
            r_out_area   <= n_toggle;
            r_out_others <= r_any_wait;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_area           = r_out_area;
    assign o_others_waiting = r_out_others;

    // Only defined marks are ever written
    a_mark_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && mark_we) |-> (mark_val == rwl_pkg::MARK_FREE ||
            mark_val == rwl_pkg::MARK_WRITER || mark_val == rwl_pkg::MARK_READ0 ||
            mark_val == rwl_pkg::MARK_READ1 || mark_val == rwl_pkg::MARK_WAIT))
        else $error("illegal client mark written");

    // The area flips only when a release commits in split mode
    a_toggle_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_toggle) |-> $past(commit && r_split &&
                                     r_cmd.kind == rwl_pkg::K_RELEASE))
        else $error("area toggle changed outside a release");

    // A result is loaded only by a commit
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(commit))
        else $error("result beat appeared without a commit");

    // Evaluation always moves on to commit
    a_eval_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_state == S_COMMIT))
        else $error("evaluation did not advance to commit");

endmodule

// ===== rtl/multi_client_reader_writer_lock_core.sv =====
// Top level of the reader/writer lock table: request stream in, result
// stream out, one configuration register. Uses rwl_pkg, rwl_front, rwl_back.
//
//  Channel  Direction  Beat contents (low bit first)            Handshake
//  s_*      in         op[1:0] client[5:2] want_read[6] pad[7]  i_s_tvalid/o_s_tready
//  m_*      out        status[1:0] area[2] others_waiting[3]    o_m_tvalid/i_m_tready
//  cfg      in         split_mode                               i_cfg_wen, no wait
//
// Steps: the back part takes each command through EVAL, to compare all
// client marks in parallel and register the summary, and COMMIT, to write back the
// mark and area toggle and load the result register; it takes one command at
// a time and pops the next queued command as it commits the last.
// Reset: synchronous, active low; every client free, toggle and split mode zero.
// Stalls: a two-entry command queue keeps requests flowing while the result
// register waits on i_m_tready; the back part holds in commit until it drains.

module multi_client_reader_writer_lock_core #(
    parameter int NUM_CLIENTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rwl_pkg::S_DATA_W-1:0]  i_s_tdata,  // op[1:0], client[5:2], want_read[6]
    // Result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rwl_pkg::M_DATA_W-1:0]  o_m_tdata,  // status[1:0], area[2], others_waiting[3]
    // Configuration
    input  logic                          i_cfg_wen,
    input  logic                          i_cfg_wdata  // split_mode
);

    logic                         q_valid;
    logic                         q_pop;
    rwl_pkg::t_cmd                q_cmd;
    logic [rwl_pkg::STATUS_W-1:0] status;
    logic                         area;
    logic                         others_waiting;

    // Accept and classify requests, queue them for the back part
    rwl_front #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tdata[1:0]),
        .i_client    (i_s_tdata[5:2]),
        .i_want_read (i_s_tdata[6]),
        .o_q_valid   (q_valid),
        .o_q_cmd     (q_cmd),
        .i_q_pop     (q_pop)
    );

    // Evaluate against the marks, write back, hold the result beat
    rwl_back #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_status         (status),
        .o_area           (area),
        .o_others_waiting (others_waiting)
    );

    // Pack result fields, pad upper bits with zeros
    assign o_m_tdata = {4'b0000, others_waiting, area, status};

endmodule

// ===== verif/rwl_lock_checker.sv =====
// Checker for the reader/writer lock table: watches the request, result and
// configuration ports, predicts each reply and compares it beat by beat.
// Depends on rwl_pkg for widths, operation, status and mark codes.

module rwl_lock_checker
    import rwl_pkg::*;
#(
    parameter int NUM_CLIENTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,  // op[1:0], client[5:2], want_read[6]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_DATA_W-1:0]  i_m_tdata,  // status[1:0], area[2], others_waiting[3]
    input  logic                 i_cfg_wen,
    input  logic                 i_cfg_wdata, // split_mode
    output int                   o_mismatches,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                others_waiting;
        logic                area;
        logic [STATUS_W-1:0] status;
    } lock_reply_t;

    t_mark       marks [NUM_CLIENTS];
    logic        area_q;
    logic        split_q;
    lock_reply_t replies_due [$];
    lock_reply_t due;
    lock_reply_t seen;

    // Apply one request to the lock table and return the reply it earns.
    function automatic lock_reply_t apply_lock_request(input logic [OP_W-1:0] op,
                                                       input logic [CLIENT_W-1:0] client,
                                                       input logic want_read);
        lock_reply_t r;
        logic        blocked;
        int          i;
        r = '0;
        r.status = ST_DONE;
        if (client < NUM_CLIENTS) begin
            case (op)
                OP_ACQUIRE: begin
                    if (want_read && split_q) begin
                        marks[client] = area_q ? MARK_READ1 : MARK_READ0;
                        r.status = ST_GRANTED;
                    end else begin
                        blocked = 1'b0;
                        for (i = 0; i < NUM_CLIENTS; i++) begin
                            if (i != client && marks[i] != MARK_FREE && marks[i] != MARK_WAIT
                                && !(want_read && marks[i] > MARK_WRITER))
                                blocked = 1'b1;
                        end
                        if (blocked) begin
                            marks[client] = MARK_WAIT;
                            r.status = ST_BUSY;
                        end else begin
                            marks[client] = want_read ? MARK_READ0 : MARK_WRITER;
                            r.status = ST_GRANTED;
                        end
                    end
                end
                OP_ABANDON: marks[client] = MARK_FREE;
                OP_RELEASE: begin
                    if (split_q && marks[client] == MARK_WRITER)
                        area_q = ~area_q;
                    marks[client] = MARK_FREE;
                end
                default: ;
            endcase
        end
        r.area = area_q;
        for (i = 0; i < NUM_CLIENTS; i++) begin
            if (i != client && marks[i] == MARK_WAIT)
                r.others_waiting = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (marks[k])
                marks[k] = MARK_FREE;
            area_q = 1'b0;
            split_q = 1'b0;
            replies_due.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_wen)
                split_q = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(apply_lock_request(i_s_tdata[1:0], i_s_tdata[5:2],
                                                         i_s_tdata[6]));
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata[3:0];
                if (replies_due.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: reply beat with no request pending: status %0d area %0d waiting %0d",
                                 $realtime, seen.status, seen.area, seen.others_waiting);
                end else begin
                    due = replies_due.pop_front();
                    if (seen.status != due.status || seen.area != due.area
                        || seen.others_waiting != due.others_waiting) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("%0t: reply mismatch: expected status %0d area %0d waiting %0d, got status %0d area %0d waiting %0d",
                                     $realtime, due.status, due.area, due.others_waiting,
                                     seen.status, seen.area, seen.others_waiting);
                    end
                end
            end
        end
        o_outstanding = replies_due.size();
    end

endmodule

// ===== verif/multi_client_reader_writer_lock_core_tb.sv =====
// Testbench top for the reader/writer lock table: clock, reset, request and
// configuration stimulus, result back-pressure and the verdict.
// Depends on rwl_pkg, rwl_lock_checker and multi_client_reader_writer_lock_core.

module multi_client_reader_writer_lock_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwl_pkg::*;

    localparam int NUM_CLIENTS = 16;
    // Op value with no meaning; the block must answer it with done
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // Slowest correct run is ~500 beats, each after the longest request gap and result stall
    localparam int CYCLE_LIMIT = 200000;
    // Settling wait after the last reply comes back
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BEATS   = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata;   // op[1:0], client[5:2], want_read[6]
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_DATA_W-1:0]  o_m_tdata;   // status[1:0], area[2], others_waiting[3]
    logic                 i_cfg_wen;
    logic                 i_cfg_wdata; // split_mode

    int mismatches;
    int outstanding;
    int cycles = 0;
    // When set, neither side idles: back-to-back beats on both channels
    bit steady;
    // Clients the stimulus has asked a lock for and not yet released
    logic [CLIENT_W-1:0] holders [$];

    multi_client_reader_writer_lock_core #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rwl_lock_checker #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: give up if the run hangs anywhere
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[multi_client_reader_writer_lock_core] ERROR");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each beat, then
    // hold ready until the beat goes through. With no stall, ready stays high.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 17);
            repeat (stall) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Drive one request beat after a random gap; return once it is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CLIENT_W-1:0] client,
                                input logic want_read);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, want_read, client, op};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    // Drop valid and hold off until every reply has come back.
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write split_mode for one cycle; only called while the block is idle.
    task automatic write_split(input logic split);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= split;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Mostly acquire/release pairs on a few clients so locks collide and
    // clients park; the rest is abandons, unused ops and stray releases.
    task automatic run_random_phase(input int beats, input bit pause_midway);
        int                  n;
        int                  pick;
        int                  idx;
        logic [CLIENT_W-1:0] c;
        logic                rd;
        for (n = 0; n < beats; n++) begin
            if (n % 20 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (pause_midway && n == beats / 2)
                drain();
            c = ($urandom_range(0, 3) == 0) ? CLIENT_W'($urandom_range(0, 15))
                                            : CLIENT_W'($urandom_range(0, 5));
            rd = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            // Keep the number of open locks bounded
            if (holders.size() > 6)
                pick = 60;
            if (pick < 50) begin
                send_request(OP_ACQUIRE, c, rd);
                holders.push_back(c);
            end else if (pick < 80 && holders.size() > 0) begin
                idx = $urandom_range(0, holders.size() - 1);
                send_request(OP_RELEASE, holders[idx], rd);
                holders.delete(idx);
            end else if (pick < 90) begin
                send_request(OP_ABANDON, c, rd);
            end else if (pick < 95) begin
                send_request(OP_UNUSED, c, rd);
            end else begin
                send_request(OP_RELEASE, c, rd);
            end
        end
    endtask

    initial begin
        int p;
        steady      = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_wen   = 1'b0;
        i_cfg_wdata = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Plain mode: writer excludes all, readers share, parked clients retry
        write_split(1'b0);
        send_request(OP_ACQUIRE, 4'd0,  1'b0);  // free table: writer granted
        send_request(OP_ACQUIRE, 4'd15, 1'b0);  // second writer parks
        send_request(OP_ACQUIRE, 4'd3,  1'b1);  // reader blocked by writer, sees a waiter
        send_request(OP_ABANDON, 4'd15, 1'b0);  // timed-out writer clears its mark
        send_request(OP_UNUSED,  4'd3,  1'b1);  // unused op changes nothing
        send_request(OP_RELEASE, 4'd0,  1'b0);
        send_request(OP_ACQUIRE, 4'd3,  1'b1);  // parked reader retries and gets in
        send_request(OP_ACQUIRE, 4'd9,  1'b1);  // readers share
        send_request(OP_ACQUIRE, 4'd12, 1'b0);  // writer blocked by readers
        send_request(OP_RELEASE, 4'd3,  1'b1);
        send_request(OP_RELEASE, 4'd9,  1'b1);
        send_request(OP_ACQUIRE, 4'd12, 1'b0);  // retry after readers left
        send_request(OP_RELEASE, 4'd12, 1'b0);
        drain();

        // Split mode: readers always get in on the current half, and a
        // writer's release flips the half
        write_split(1'b1);
        send_request(OP_ACQUIRE, 4'd5,  1'b0);
        send_request(OP_ACQUIRE, 4'd6,  1'b1);  // reader beside a writer, half 0
        send_request(OP_ACQUIRE, 4'd10, 1'b0);  // second writer parks
        send_request(OP_RELEASE, 4'd5,  1'b0);  // writer leaves: half flips
        send_request(OP_ACQUIRE, 4'd7,  1'b1);  // reader on half 1
        send_request(OP_RELEASE, 4'd10, 1'b0);  // release of a parked client
        send_request(OP_ACQUIRE, 4'd10, 1'b0);  // readers of either half block it
        send_request(OP_RELEASE, 4'd6,  1'b1);
        send_request(OP_RELEASE, 4'd7,  1'b1);
        send_request(OP_ACQUIRE, 4'd10, 1'b0);
        send_request(OP_RELEASE, 4'd10, 1'b0);  // flips the half back
        send_request(OP_UNUSED,  4'd15, 1'b1);
        drain();

        // Random phases, alternating the mode; one phase pauses midway until
        // the block has answered everything
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_split(p[0]);
            run_random_phase(PHASE_BEATS, p == 2);
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("[multi_client_reader_writer_lock_core] OK");
        else
            $display("[multi_client_reader_writer_lock_core] ERROR");
        $finish;
    end

endmodule
